// ===== sv/gss_pkg.sv =====
// Package of the gear shift sequencer: codes, register indexes, reset values and types.
`default_nettype none

package gss_pkg;

    localparam int unsigned SpeedW  = 14;
    localparam int unsigned SampleW = 12;
    localparam int unsigned TorqueW = 16;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned CfgIdxW = 3;

    // Shift request codes.
    localparam logic [2:0] REQ_NONE   = 3'd0;
    localparam logic [2:0] REQ_UP     = 3'd1;
    localparam logic [2:0] REQ_DOWN   = 3'd2;
    localparam logic [2:0] REQ_FORCED = 3'd4;

    // Gear codes.
    localparam logic [1:0] GEAR_FIRST  = 2'd1;
    localparam logic [1:0] GEAR_SECOND = 2'd2;

    // Drive select code for no drive change.
    localparam logic [2:0] DRIVE_NONE = 3'd0;

    // Phase taken after the last phase ends.
    localparam logic [1:0] PHASE_RESTART = 2'd1;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] REG_UPSHIFT_SPEED  = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_DOWNSHIFT_SPEED = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_FORCED_SPEED   = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_OFF_THR        = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_SYNC_THR       = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_ENGAGE_THR     = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_END_THR        = 3'd6;
    localparam logic [CfgIdxW-1:0] REG_TORQUE_CEIL    = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [SpeedW-1:0]  RST_UPSHIFT_SPEED   = 14'd5000;
    localparam logic [SpeedW-1:0]  RST_DOWNSHIFT_SPEED = 14'd3000;
    localparam logic [SpeedW-1:0]  RST_FORCED_SPEED    = 14'd1000;
    localparam logic [SampleW-1:0] RST_OFF_THR         = 12'd3072;
    localparam logic [SampleW-1:0] RST_SYNC_THR        = 12'd2048;
    localparam logic [SampleW-1:0] RST_ENGAGE_THR      = 12'd1024;
    localparam logic [SampleW-1:0] RST_END_THR         = 12'd512;
    localparam logic [TorqueW-1:0] RST_TORQUE_CEIL     = 16'd6500;

    typedef struct packed {
        logic [SpeedW-1:0]         upshift_speed;
        logic [SpeedW-1:0]         downshift_speed;
        logic [SpeedW-1:0]         forced_down_speed;
        logic [SampleW-1:0]        off_threshold;
        logic [SampleW-1:0]        sync_threshold;
        logic [SampleW-1:0]        engage_threshold;
        logic [SampleW-1:0]        end_threshold;
        logic signed [TorqueW-1:0] torque_ceiling;
    } t_cfg;

    typedef struct packed {
        logic [1:0]                gear;
        logic [SpeedW-1:0]         shaft_speed;
        logic signed [TorqueW-1:0] torque;
        logic [SampleW-1:0]        actuator_sample;
    } t_item;

    typedef struct packed {
        logic [2:0] req;
        logic [1:0] phase;
        logic       flag;
    } t_state;

    typedef struct packed {
        logic [2:0] shift_request;
        logic [1:0] phase;
        logic       request_pending;
        logic [2:0] drive_select;
    } t_result;

endpackage

`default_nettype wire

// ===== sv/gear_shift_sequencer.sv =====
// Top level of the gear shift sequencer: input register, step logic, result register.
//
//  Channel | Direction | Handshake                 | Payload
//  --------+-----------+---------------------------+------------------------------------------
//  in      | in        | i_in_valid / o_in_stall   | gear, shaft_speed, torque, actuator_sample
//  out     | out       | o_out_valid / i_out_stall | shift_request, phase, request_pending,
//          |           |                           | drive_select
//  cfg     | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One item per cycle unless the output stalls; results are held in the result register.
// The input register feeds the decision and phase logic, whose result and new state
// are written together into the result and state registers in the same cycle.
// Reset clears the state, the valid flags and loads the register defaults.
// A stall at the output holds the result; the input register then fills and stalls.
`default_nettype none

module gear_shift_sequencer (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [1:0]                   i_gear,
    input  wire logic [gss_pkg::SpeedW-1:0]   i_shaft_speed,
    input  wire logic signed [gss_pkg::TorqueW-1:0] i_torque,
    input  wire logic [gss_pkg::SampleW-1:0]  i_actuator_sample,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [2:0]                        o_shift_request,
    output logic [1:0]                        o_phase,
    output logic                              o_request_pending,
    output logic [2:0]                        o_drive_select,
    input  wire logic                         i_cfg_we,
    input  wire logic [gss_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [gss_pkg::CfgW-1:0]     i_cfg_data
);
    import gss_pkg::*;

    t_cfg    cfg;
    t_item   r_item;
    logic    r_in_vld;
    logic    n_in_vld;
    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result r_result;
    logic    r_out_vld;
    logic    n_out_vld;
    logic    advance;
    logic    in_take;

    gss_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gss_step u_step (
        .i_cfg    (cfg),
        .i_item   (r_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // The held item moves on when the result register is free or being drained.
    assign advance    = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    assign n_in_vld  = in_take || (r_in_vld && !advance);
    assign n_out_vld = advance || (r_out_vld && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= '0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
            if (advance) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item.gear            <= i_gear;
            r_item.shaft_speed     <= i_shaft_speed;
            r_item.torque          <= i_torque;
            r_item.actuator_sample <= i_actuator_sample;
        end
        if (advance) begin
            r_result <= step_result;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_shift_request   = r_result.shift_request;
    assign o_phase           = r_result.phase;
    assign o_request_pending = r_result.request_pending;
    assign o_drive_select    = r_result.drive_select;

`ifndef SYNTHESIS
    // The phase only leaves zero during an upshift, and requests change only at phase zero.
    a_phase_needs_upshift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase != 2'd0 |-> r_state.req == REQ_UP)
        else $error("phase nonzero without an upshift request");

    // A drive level names the phase that holds it.
    a_drive_matches_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_drive_select != DRIVE_NONE |->
            o_shift_request == REQ_UP && {1'b0, o_phase} == o_drive_select - 3'd1)
        else $error("drive level does not match the phase");

    // The pending flag is sticky once set.
    a_flag_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.flag |=> r_state.flag)
        else $error("request flag cleared");

    // Any raised request leaves the pending flag set.
    a_request_sets_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_shift_request != REQ_NONE |-> o_request_pending)
        else $error("request shown without the pending flag");
`endif

endmodule

`default_nettype wire

// ===== sv/gss_cfg_regs.sv =====
// Configuration register file of the gear shift sequencer.
`default_nettype none

module gss_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic [gss_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [gss_pkg::CfgW-1:0]     i_cfg_data,
    output gss_pkg::t_cfg                     o_cfg
);
    import gss_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.upshift_speed     <= RST_UPSHIFT_SPEED;
            r_cfg.downshift_speed   <= RST_DOWNSHIFT_SPEED;
            r_cfg.forced_down_speed <= RST_FORCED_SPEED;
            r_cfg.off_threshold     <= RST_OFF_THR;
            r_cfg.sync_threshold    <= RST_SYNC_THR;
            r_cfg.engage_threshold  <= RST_ENGAGE_THR;
            r_cfg.end_threshold     <= RST_END_THR;
            r_cfg.torque_ceiling    <= RST_TORQUE_CEIL;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_UPSHIFT_SPEED:   r_cfg.upshift_speed     <= i_cfg_data[SpeedW-1:0];
                REG_DOWNSHIFT_SPEED: r_cfg.downshift_speed   <= i_cfg_data[SpeedW-1:0];
                REG_FORCED_SPEED:    r_cfg.forced_down_speed <= i_cfg_data[SpeedW-1:0];
                REG_OFF_THR:         r_cfg.off_threshold     <= i_cfg_data[SampleW-1:0];
                REG_SYNC_THR:        r_cfg.sync_threshold    <= i_cfg_data[SampleW-1:0];
                REG_ENGAGE_THR:      r_cfg.engage_threshold  <= i_cfg_data[SampleW-1:0];
                REG_END_THR:         r_cfg.end_threshold     <= i_cfg_data[SampleW-1:0];
                REG_TORQUE_CEIL:     r_cfg.torque_ceiling    <= i_cfg_data[TorqueW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/gss_step.sv =====
// Shift decision and upshift phase cascade for one item, purely combinational.
`default_nettype none

module gss_step (
    input  wire gss_pkg::t_cfg    i_cfg,
    input  wire gss_pkg::t_item   i_item,
    input  wire gss_pkg::t_state  i_state,
    output gss_pkg::t_state  o_state,
    output gss_pkg::t_result o_result
);
    import gss_pkg::*;

    logic             torque_ok;
    logic [3:0]       hold;
    t_state           n_state;
    logic [2:0]       drive;
    logic [1:0]       start_phase;

    assign torque_ok = $signed(i_item.torque) <= $signed(i_cfg.torque_ceiling);

    // A phase holds while the sample stays at or above its threshold.
    assign hold[0] = i_item.actuator_sample >= i_cfg.off_threshold;
    assign hold[1] = i_item.actuator_sample >= i_cfg.sync_threshold;
    assign hold[2] = i_item.actuator_sample >= i_cfg.engage_threshold;
    assign hold[3] = i_item.actuator_sample >= i_cfg.end_threshold;

    always_comb begin
        n_state = i_state;
        drive   = DRIVE_NONE;

        if (i_state.phase == 2'd0) begin
            if (i_item.gear == GEAR_FIRST) begin
                if (i_item.shaft_speed >= i_cfg.upshift_speed && torque_ok) begin
                    n_state.req  = REQ_UP;
                    n_state.flag = 1'b1;
                end
            end else if (i_item.gear == GEAR_SECOND) begin
                if (i_item.shaft_speed <= i_cfg.downshift_speed && torque_ok) begin
                    n_state.req  = REQ_DOWN;
                    n_state.flag = 1'b1;
                end
                // The forced downshift wins over a plain downshift.
                if (i_item.shaft_speed <= i_cfg.forced_down_speed) begin
                    n_state.req  = REQ_FORCED;
                    n_state.flag = 1'b1;
                end
            end
        end

        start_phase = n_state.phase;

        // The phases fall through from the current one; the first that holds
        // wins. If none holds, the last phase ended and the cascade restarts.
        if (n_state.req == REQ_UP) begin
            n_state.phase = PHASE_RESTART;
            for (int p = 3; p >= 0; p--) begin
                if (2'(p) >= start_phase && hold[p]) begin
                    n_state.phase = 2'(p);
                    drive         = 3'(p + 1);
                end
            end
        end
    end

    assign o_state                  = n_state;
    assign o_result.shift_request   = n_state.req;
    assign o_result.phase           = n_state.phase;
    assign o_result.request_pending = n_state.flag;
    assign o_result.drive_select    = drive;

endmodule

`default_nettype wire

// ===== tb/sv/gss_shift_monitor.sv =====
// Channel monitor for the gear shift sequencer: predicts every result and compares it.
module gss_shift_monitor
    import gss_pkg::*;
(
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_stall,
    input  wire logic [1:0]                  i_gear,
    input  wire logic [SpeedW-1:0]           i_shaft_speed,
    input  wire logic signed [TorqueW-1:0]   i_torque,
    input  wire logic [SampleW-1:0]          i_actuator_sample,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_stall,
    input  wire logic [2:0]                  i_shift_request,
    input  wire logic [1:0]                  i_phase,
    input  wire logic                        i_request_pending,
    input  wire logic [2:0]                  i_drive_select,
    input  wire logic                        i_cfg_we,
    input  wire logic [CfgIdxW-1:0]          i_cfg_index,
    input  wire logic [CfgW-1:0]             i_cfg_data,
    output int                               o_fail_count,
    output int                               o_waiting,
    output int                               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    t_cfg       shift_cfg;
    logic [2:0] shift_req;
    logic [1:0] upshift_phase;
    logic       request_seen;

    t_result    pending_shift_results[$];
    int         fail_total    = 0;
    int         checked_total = 0;
    int         waiting_count = 0;

    assign o_fail_count = fail_total;
    assign o_waiting    = waiting_count;
    assign o_checked    = checked_total;

    task automatic apply_reg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        case (idx)
            REG_UPSHIFT_SPEED:   shift_cfg.upshift_speed     = data[SpeedW-1:0];
            REG_DOWNSHIFT_SPEED: shift_cfg.downshift_speed   = data[SpeedW-1:0];
            REG_FORCED_SPEED:    shift_cfg.forced_down_speed = data[SpeedW-1:0];
            REG_OFF_THR:         shift_cfg.off_threshold     = data[SampleW-1:0];
            REG_SYNC_THR:        shift_cfg.sync_threshold    = data[SampleW-1:0];
            REG_ENGAGE_THR:      shift_cfg.engage_threshold  = data[SampleW-1:0];
            REG_END_THR:         shift_cfg.end_threshold     = data[SampleW-1:0];
            REG_TORQUE_CEIL:     shift_cfg.torque_ceiling    = data[TorqueW-1:0];
            default: ;
        endcase
    endtask

    // Decision and upshift phase cascade for one control tick; updates the shadow state.
    function automatic t_result predict_shift_step(input t_item it);
        t_result            r;
        logic [2:0]         drive;
        logic               torque_ok;
        logic [SampleW-1:0] thr [4];
        int                 start;
        bit                 held;
        drive     = DRIVE_NONE;
        torque_ok = $signed(it.torque) <= $signed(shift_cfg.torque_ceiling);
        thr[0]    = shift_cfg.off_threshold;
        thr[1]    = shift_cfg.sync_threshold;
        thr[2]    = shift_cfg.engage_threshold;
        thr[3]    = shift_cfg.end_threshold;

        if (upshift_phase == 2'd0) begin
            if (it.gear == GEAR_FIRST) begin
                if (it.shaft_speed >= shift_cfg.upshift_speed && torque_ok) begin
                    shift_req    = REQ_UP;
                    request_seen = 1'b1;
                end
            end else if (it.gear == GEAR_SECOND) begin
                if (it.shaft_speed <= shift_cfg.downshift_speed && torque_ok) begin
                    shift_req    = REQ_DOWN;
                    request_seen = 1'b1;
                end
                // The forced downshift wins over a plain downshift of the same tick.
                if (it.shaft_speed <= shift_cfg.forced_down_speed) begin
                    shift_req    = REQ_FORCED;
                    request_seen = 1'b1;
                end
            end
        end

        // Phases fall through within one tick until one holds its drive level.
        // Leaving the last phase wraps back to the restart phase with no drive.
        if (shift_req == REQ_UP) begin
            start = int'(upshift_phase);
            held  = 1'b0;
            for (int k = 0; k < 4; k++) begin
                if (!held && k >= start) begin
                    if (it.actuator_sample >= thr[k]) begin
                        drive = 3'(k + 1);
                        held  = 1'b1;
                    end else begin
                        upshift_phase = (k == 3) ? PHASE_RESTART : 2'(k + 1);
                    end
                end
            end
        end

        r.shift_request   = shift_req;
        r.phase           = upshift_phase;
        r.request_pending = request_seen;
        r.drive_select    = drive;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [2:0] want, input logic [2:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_item   item;
        t_result want;
        if (!i_rst_n) begin
            shift_cfg.upshift_speed     = RST_UPSHIFT_SPEED;
            shift_cfg.downshift_speed   = RST_DOWNSHIFT_SPEED;
            shift_cfg.forced_down_speed = RST_FORCED_SPEED;
            shift_cfg.off_threshold     = RST_OFF_THR;
            shift_cfg.sync_threshold    = RST_SYNC_THR;
            shift_cfg.engage_threshold  = RST_ENGAGE_THR;
            shift_cfg.end_threshold     = RST_END_THR;
            shift_cfg.torque_ceiling    = RST_TORQUE_CEIL;
            shift_req     = REQ_NONE;
            upshift_phase = 2'd0;
            request_seen  = 1'b0;
            pending_shift_results.delete();
        end else begin
            if (i_cfg_we) begin
                apply_reg_write(i_cfg_index, i_cfg_data);
            end
            if (i_out_valid && !i_out_stall) begin
                if (pending_shift_results.size() == 0) begin
                    $error("result with no item waiting: shift_request %0d phase %0d drive %0d",
                           i_shift_request, i_phase, i_drive_select);
                    fail_total++;
                end else begin
                    want = pending_shift_results.pop_front();
                    check_field("shift_request", want.shift_request, i_shift_request);
                    check_field("phase", 3'(want.phase), 3'(i_phase));
                    check_field("request_pending", 3'(want.request_pending),
                                3'(i_request_pending));
                    check_field("drive_select", want.drive_select, i_drive_select);
                    checked_total++;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                item.gear            = i_gear;
                item.shaft_speed     = i_shaft_speed;
                item.torque          = i_torque;
                item.actuator_sample = i_actuator_sample;
                pending_shift_results.push_back(predict_shift_step(item));
            end
        end
        waiting_count <= pending_shift_results.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the gear shift sequencer testbench: clock, reset, stimulus and verdict.
module tb_top import gss_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] GEAR_NEUTRAL = 2'd0;
    localparam logic [1:0] GEAR_UNUSED  = 2'd3;
    localparam int         SpeedMax     = (1 << SpeedW) - 1;
    localparam int         SampleMax    = (1 << SampleW) - 1;
    localparam int         TorqueMin    = -(1 << (TorqueW - 1));
    localparam int         TorqueMax    = (1 << (TorqueW - 1)) - 1;

    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      i_in_valid        = 1'b0;
    logic [1:0]                i_gear            = '0;
    logic [SpeedW-1:0]         i_shaft_speed     = '0;
    logic signed [TorqueW-1:0] i_torque          = '0;
    logic [SampleW-1:0]        i_actuator_sample = '0;
    logic                      i_out_stall       = 1'b0;
    logic                      i_cfg_we          = 1'b0;
    logic [CfgIdxW-1:0]        i_cfg_index       = '0;
    logic [CfgW-1:0]           i_cfg_data        = '0;

    logic                      o_in_stall;
    logic                      o_out_valid;
    logic [2:0]                o_shift_request;
    logic [1:0]                o_phase;
    logic                      o_request_pending;
    logic [2:0]                o_drive_select;

    int   fail_count;
    int   waiting;
    int   checked;
    int   src_idle_pct  = 0;
    int   rcv_idle_pct  = 0;
    int   items_sent    = 0;
    int   settings_used = 0;
    t_cfg cur_cfg;

    gear_shift_sequencer u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_gear            (i_gear),
        .i_shaft_speed     (i_shaft_speed),
        .i_torque          (i_torque),
        .i_actuator_sample (i_actuator_sample),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_shift_request   (o_shift_request),
        .o_phase           (o_phase),
        .o_request_pending (o_request_pending),
        .o_drive_select    (o_drive_select),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    gss_shift_monitor u_shift_monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_gear            (i_gear),
        .i_shaft_speed     (i_shaft_speed),
        .i_torque          (i_torque),
        .i_actuator_sample (i_actuator_sample),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_shift_request   (o_shift_request),
        .i_phase           (o_phase),
        .i_request_pending (o_request_pending),
        .i_drive_select    (o_drive_select),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_fail_count      (fail_count),
        .o_waiting         (waiting),
        .o_checked         (checked)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < rcv_idle_pct);
    end

    initial begin
        #1ms;
        $display("gear_shift_sequencer test failed");
        $finish;
    end

    task automatic set_idling(input int src_pct, input int rcv_pct);
        src_idle_pct = src_pct;
        rcv_idle_pct <= rcv_pct;
    endtask

    task automatic send_item(input logic [1:0] gear, input logic [SpeedW-1:0] speed,
                             input logic signed [TorqueW-1:0] torque,
                             input logic [SampleW-1:0] sample);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_gear            <= gear;
        i_shaft_speed     <= speed;
        i_torque          <= torque;
        i_actuator_sample <= sample;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (waiting != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Unused upper data bits carry random garbage; the registers must drop them.
    task automatic load_setting(input t_cfg c);
        drain_results();
        write_reg(REG_UPSHIFT_SPEED,   {2'($urandom), c.upshift_speed});
        write_reg(REG_DOWNSHIFT_SPEED, {2'($urandom), c.downshift_speed});
        write_reg(REG_FORCED_SPEED,    {2'($urandom), c.forced_down_speed});
        write_reg(REG_OFF_THR,         {4'($urandom), c.off_threshold});
        write_reg(REG_SYNC_THR,        {4'($urandom), c.sync_threshold});
        write_reg(REG_ENGAGE_THR,      {4'($urandom), c.engage_threshold});
        write_reg(REG_END_THR,         {4'($urandom), c.end_threshold});
        write_reg(REG_TORQUE_CEIL,     c.torque_ceiling);
        i_cfg_we <= 1'b0;
        cur_cfg = c;
        settings_used++;
    endtask

    function automatic t_cfg random_setting(input bit hold_phase);
        t_cfg c;
        c.upshift_speed     = SpeedW'($urandom);
        c.downshift_speed   = SpeedW'($urandom);
        c.forced_down_speed = SpeedW'($urandom);
        c.off_threshold     = SampleW'($urandom);
        c.sync_threshold    = SampleW'($urandom);
        c.engage_threshold  = SampleW'($urandom);
        c.end_threshold     = SampleW'($urandom);
        c.torque_ceiling    = TorqueW'($urandom);
        // A zero off threshold keeps phase zero, so shift decisions stay live.
        if (hold_phase) begin
            c.off_threshold = '0;
        end
        return c;
    endfunction

    function automatic int jitter_around(input int center, input int lo, input int hi);
        int v;
        v = center + int'($urandom_range(0, 16)) - 8;
        if (v < lo) begin
            v = lo;
        end
        if (v > hi) begin
            v = hi;
        end
        return v;
    endfunction

    // Decision items aim at the speed and torque limits; cascade items at the thresholds.
    task automatic send_random_items(input int count, input bit cascade);
        logic [1:0]                gear;
        logic [SpeedW-1:0]         speed;
        logic signed [TorqueW-1:0] torque;
        logic [SampleW-1:0]        sample;
        int                        pick;
        repeat (count) begin
            gear   = 2'($urandom);
            speed  = SpeedW'($urandom);
            torque = TorqueW'($urandom);
            sample = SampleW'($urandom);
            if (!cascade) begin
                pick = $urandom_range(0, 9);
                if (pick >= 6) begin
                    gear = GEAR_SECOND;
                end else if (pick >= 2) begin
                    gear = GEAR_FIRST;
                end
                case ($urandom_range(0, 3))
                    0: speed = SpeedW'(jitter_around(int'(cur_cfg.upshift_speed), 0, SpeedMax));
                    1: speed = SpeedW'(jitter_around(int'(cur_cfg.downshift_speed), 0, SpeedMax));
                    2: speed = SpeedW'(jitter_around(int'(cur_cfg.forced_down_speed), 0,
                                                     SpeedMax));
                    default: ;
                endcase
                case ($urandom_range(0, 4))
                    0, 1: torque = TorqueW'(jitter_around(int'($signed(cur_cfg.torque_ceiling)),
                                                          TorqueMin, TorqueMax));
                    2: torque = TorqueW'(jitter_around(0, TorqueMin, TorqueMax));
                    default: ;
                endcase
            end else begin
                case ($urandom_range(0, 5))
                    0: sample = SampleW'(jitter_around(int'(cur_cfg.sync_threshold), 0,
                                                       SampleMax));
                    1: sample = SampleW'(jitter_around(int'(cur_cfg.engage_threshold), 0,
                                                       SampleMax));
                    2: sample = SampleW'(jitter_around(int'(cur_cfg.end_threshold), 0,
                                                       SampleMax));
                    3: sample = SampleW'(jitter_around(int'(cur_cfg.off_threshold), 0,
                                                       SampleMax));
                    default: ;
                endcase
            end
            send_item(gear, speed, torque, sample);
        end
    endtask

    initial begin
        t_cfg c;
        cur_cfg.upshift_speed     = RST_UPSHIFT_SPEED;
        cur_cfg.downshift_speed   = RST_DOWNSHIFT_SPEED;
        cur_cfg.forced_down_speed = RST_FORCED_SPEED;
        cur_cfg.off_threshold     = RST_OFF_THR;
        cur_cfg.sync_threshold    = RST_SYNC_THR;
        cur_cfg.engage_threshold  = RST_ENGAGE_THR;
        cur_cfg.end_threshold     = RST_END_THR;
        cur_cfg.torque_ceiling    = RST_TORQUE_CEIL;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Shift decisions at the reset limits, before any upshift leaves phase zero.
        set_idling(38, 61);
        send_item(GEAR_NEUTRAL, 16383, -32768, 0);
        send_item(GEAR_UNUSED, 16383, 32767, 4095);
        send_item(GEAR_SECOND, 2000, 0, 1234);
        send_item(GEAR_SECOND, 0, 32767, 0);
        send_item(GEAR_SECOND, 500, 100, 4095);
        send_item(GEAR_SECOND, 3001, -1, 2000);
        send_item(GEAR_SECOND, 3000, 6500, 0);
        send_item(GEAR_SECOND, 3000, 6501, 0);
        send_item(GEAR_FIRST, 4999, 0, 100);
        send_item(GEAR_FIRST, 5000, 6501, 100);
        send_item(GEAR_FIRST, 16383, -32768, 4095);
        send_item(GEAR_FIRST, 5000, 6500, 3072);
        send_item(GEAR_SECOND, 1000, 0, 3071);

        // Random decisions with phase zero held, over random and extreme limits.
        load_setting(random_setting(1'b1));
        send_random_items(300, 1'b0);
        c = '0;
        c.torque_ceiling = 16'sh8000;
        load_setting(c);
        send_random_items(300, 1'b0);
        set_idling(61, 38);
        c.upshift_speed     = '1;
        c.downshift_speed   = '1;
        c.forced_down_speed = '1;
        c.off_threshold     = '0;
        c.sync_threshold    = '1;
        c.engage_threshold  = '1;
        c.end_threshold     = '1;
        c.torque_ceiling    = 16'sh7FFF;
        load_setting(c);
        send_random_items(300, 1'b0);

        // Walk the upshift phases at the reset thresholds, including the wrap to phase one.
        c.upshift_speed     = RST_UPSHIFT_SPEED;
        c.downshift_speed   = RST_DOWNSHIFT_SPEED;
        c.forced_down_speed = RST_FORCED_SPEED;
        c.off_threshold     = RST_OFF_THR;
        c.sync_threshold    = RST_SYNC_THR;
        c.engage_threshold  = RST_ENGAGE_THR;
        c.end_threshold     = RST_END_THR;
        c.torque_ceiling    = RST_TORQUE_CEIL;
        load_setting(c);
        send_item(GEAR_FIRST, 6000, 0, 3000);
        send_item(GEAR_SECOND, 0, 0, 2048);
        send_item(GEAR_FIRST, 6000, 0, 2047);
        send_item(GEAR_FIRST, 6000, 0, 1023);
        send_item(GEAR_NEUTRAL, 0, 0, 512);
        send_item(GEAR_FIRST, 6000, 0, 511);
        send_item(GEAR_SECOND, 16383, 0, 0);
        send_item(GEAR_FIRST, 6000, 0, 4095);
        send_item(GEAR_FIRST, 6000, 0, 100);

        // Once past phase zero the block cycles through the upshift phases for good.
        load_setting(random_setting(1'b0));
        send_random_items(300, 1'b1);
        set_idling(0, 0);
        c.upshift_speed     = '1;
        c.downshift_speed   = '1;
        c.forced_down_speed = '1;
        c.off_threshold     = '1;
        c.sync_threshold    = '1;
        c.engage_threshold  = '1;
        c.end_threshold     = '1;
        c.torque_ceiling    = 16'sh7FFF;
        load_setting(c);
        send_random_items(300, 1'b1);
        load_setting(random_setting(1'b0));
        send_random_items(300, 1'b1);

        drain_results();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d items under %0d register settings: shift decisions in every gear,",
                 items_sent, settings_used);
        $display("then the upshift phase cascade; %0d results compared, %0d mismatches.",
                 checked, fail_count);
        if (fail_count == 0) begin
            $display("gear_shift_sequencer test passed");
        end else begin
            $display("gear_shift_sequencer test failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/gss_pkg.sv
sv/gss_cfg_regs.sv
sv/gss_step.sv
sv/gear_shift_sequencer.sv
tb/sv/gss_shift_monitor.sv
tb/sv/tb_top.sv
